>>> src/aetf_pkg.sv
// ----------------------------------------------------------------------------
// aetf_pkg
// Shared types, codes and the sine table of the echo / modulation effect block.
// ----------------------------------------------------------------------------
package aetf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 16;
  localparam int PHASE_W      = 24;
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int MUL_B_W      = 32;   // widest serial multiplier operand
  localparam int PROD_W       = 50;   // 18-bit signed x 32-bit unsigned
  localparam int DLY_W        = 17;   // up to 7 * 16383 frames
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [1:0] {
    MODE_ECHO,
    MODE_MULTI,
    MODE_AM,
    MODE_MOD_DELAY
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_CHANNELS,
    REG_TAP_DELAY,
    REG_GAIN,
    REG_TAP_COUNT,
    REG_LFO_STEP,
    REG_BASE,
    REG_SWING
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_WGT,
    S_TAP,
    S_RD,
    S_RDW,
    S_TMUL,
    S_NEXT,
    S_AMG,
    S_AMX,
    S_DLY,
    S_FIN,
    S_OUT
  } state_t;

  typedef logic signed [SAMPLE_W-1:0] sine_tab_t [SINE_ENTRIES];

  // Q1.15 sine, Taylor series in Q30 over the first quadrant, mirrored.
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(int unsigned i);
    longint t, q, r, x, x2, term, sum, v;
    t = longint'(i) * 4;
    q = t / SINE_ENTRIES;
    r = t % SINE_ENTRIES;
    if (q % 2 == 1) r = SINE_ENTRIES - r;
    x = r * HALF_PI_Q30 / SINE_ENTRIES;
    x2 = (x * x) >>> 30;
    term = x;
    sum = x;
    term = ((term * x2) >>> 30) / 6;   sum = sum - term;
    term = ((term * x2) >>> 30) / 20;  sum = sum + term;
    term = ((term * x2) >>> 30) / 42;  sum = sum - term;
    term = ((term * x2) >>> 30) / 72;  sum = sum + term;
    term = ((term * x2) >>> 30) / 110; sum = sum - term;
    term = ((term * x2) >>> 30) / 156; sum = sum + term;
    if (sum < 0) sum = 0;
    v = (sum + 16384) >>> 15;
    if (v > 32767) v = 32767;
    if (q >= 2) v = -v;
    return SAMPLE_W'(v);
  endfunction

  function automatic sine_tab_t sine_table();
    sine_tab_t tab;
    for (int i = 0; i < SINE_ENTRIES; i++) tab[i] = sine_entry(i);
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = sine_table();

endpackage

>>> src/aetf_if.sv
// ----------------------------------------------------------------------------
// aetf_in_if / aetf_out_if
// Valid/ready item channels for input samples and processed samples.
// ----------------------------------------------------------------------------
interface aetf_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface aetf_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   sample_out;
  logic                 clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

>>> src/audio_echo_tremolo_flanger.sv
// ----------------------------------------------------------------------------
// audio_echo_tremolo_flanger
// Echo, multi-echo, tremolo and modulated delay on interleaved PCM samples.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  din     | in  | valid / ready      | sample_in  (s16)
//  dout    | out | valid / ready      | sample_out (s16), clipped
//  apb     | in  | psel/penable/pwrite| paddr[4:2] = register, pwdata
//
// Every product goes through one shift-add multiplier that consumes one bit
// of its unsigned operand per cycle up to the top set bit. A skipped tap
// saves its memory read and its product. An item waits in S_OUT while dout
// is full.
// Reset clears the control state and loads the register defaults; the history
// memory is not cleared, a slot is read only after it was written.
// A finished item waits in the output register; the next item is accepted
// meanwhile and only stalls at its own result if dout is still full.
// ----------------------------------------------------------------------------
module audio_echo_tremolo_flanger #(
  parameter int HISTORY_FRAMES = 65536,
  parameter int MAX_CHANNELS   = 2,
  parameter int MAX_TAPS       = 5
) (
  input  logic        clk,
  input  logic        rst,
  aetf_in_if.sink     din,
  aetf_out_if.source  dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW    = aetf_pkg::PROD_W;
  localparam int DW    = aetf_pkg::DLY_W;
  localparam int FW    = $clog2(HISTORY_FRAMES);
  localparam int FSW   = $clog2(HISTORY_FRAMES + 1);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DEPTH = HISTORY_FRAMES * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TNW   = $clog2(MAX_TAPS + 1);
  localparam int CMPW  = ((FSW > DW) ? FSW : DW) + 1;

  localparam logic signed [PW-1:0] SAT_HI  = PW'(32767);
  localparam logic signed [PW-1:0] SAT_LO  = -PW'(32768);
  localparam logic signed [PW-1:0] BIAS_16 = PW'(65535);
  localparam logic signed [PW-1:0] BIAS_31 = PW'(64'h7FFF_FFFF);
  localparam logic signed [PW-1:0] ONE_Q31 = PW'(64'h8000_0000);

  // ---------------- configuration registers ----------------
  aetf_pkg::mode_t cfg_mode;
  logic [1:0]  cfg_channels;
  logic [13:0] cfg_tap_delay;
  logic [15:0] cfg_gain;
  logic [2:0]  cfg_tap_count;
  logic [15:0] cfg_lfo_step;
  logic [11:0] cfg_base;
  logic [12:0] cfg_swing;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode      <= aetf_pkg::MODE_ECHO;
      cfg_channels  <= 2'd2;
      cfg_tap_delay <= 14'd11025;
      cfg_gain      <= 16'd45875;
      cfg_tap_count <= 3'd5;
      cfg_lfo_step  <= 16'd1902;
      cfg_base      <= 12'd441;
      cfg_swing     <= 13'd4410;
    end else if (cfg_wr) begin
      case (aetf_pkg::reg_idx_t'(paddr[4:2]))
        aetf_pkg::REG_MODE:      cfg_mode      <= aetf_pkg::mode_t'(pwdata[1:0]);
        aetf_pkg::REG_CHANNELS:  cfg_channels  <= pwdata[1:0];
        aetf_pkg::REG_TAP_DELAY: cfg_tap_delay <= pwdata[13:0];
        aetf_pkg::REG_GAIN:      cfg_gain      <= pwdata[15:0];
        aetf_pkg::REG_TAP_COUNT: cfg_tap_count <= pwdata[2:0];
        aetf_pkg::REG_LFO_STEP:  cfg_lfo_step  <= pwdata[15:0];
        aetf_pkg::REG_BASE:      cfg_base      <= pwdata[11:0];
        aetf_pkg::REG_SWING:     cfg_swing     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (aetf_pkg::reg_idx_t'(paddr[4:2]))
      aetf_pkg::REG_MODE:      prdata = 32'(cfg_mode);
      aetf_pkg::REG_CHANNELS:  prdata = 32'(cfg_channels);
      aetf_pkg::REG_TAP_DELAY: prdata = 32'(cfg_tap_delay);
      aetf_pkg::REG_GAIN:      prdata = 32'(cfg_gain);
      aetf_pkg::REG_TAP_COUNT: prdata = 32'(cfg_tap_count);
      aetf_pkg::REG_LFO_STEP:  prdata = 32'(cfg_lfo_step);
      aetf_pkg::REG_BASE:      prdata = 32'(cfg_base);
      aetf_pkg::REG_SWING:     prdata = 32'(cfg_swing);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- stream state ----------------
  aetf_pkg::state_t state, state_next;

  logic [FSW-1:0]  frames_seen;
  logic [FW-1:0]   write_frame;
  logic [CHW-1:0]  channel_index;
  logic [23:0]     lfo_phase;

  // effective channel count: zero means one, clamp to what the memory holds
  logic [1:0] cc_eff, nch;
  logic [CHW-1:0] ch_now;
  assign cc_eff = (cfg_channels == 2'd0) ? 2'd1 : cfg_channels;
  assign nch    = (32'(cc_eff) > MAX_CHANNELS) ? 2'(MAX_CHANNELS) : cc_eff;
  assign ch_now = (32'(channel_index) >= 32'(nch)) ? '0 : channel_index;

  // ---------------- item datapath ----------------
  logic signed [15:0]   x;
  logic signed [15:0]   sine;
  logic [CHW-1:0]       cur_ch;
  logic signed [PW-1:0] acc;
  logic [16:0]          w;        // tap weight, Q16 up to 1.0
  logic [DW-1:0]        d;        // tap delay in frames
  logic [TNW-1:0]       tapn, ntaps;
  logic [AW-1:0]        raddr;
  logic signed [15:0]   rdata;
  logic signed [15:0]   res_q;
  logic                 clip_q;

  // bit-serial multiplier: mp += ma while mb shifts out LSB first
  logic signed [PW-1:0] ma, mp;
  logic [aetf_pkg::MUL_B_W-1:0] mb;
  logic mul_done, mul_run;
  assign mul_done = (mb == '0);
  assign mul_run  = (state == aetf_pkg::S_WGT) || (state == aetf_pkg::S_TMUL) ||
                    (state == aetf_pkg::S_AMG) || (state == aetf_pkg::S_AMX) ||
                    (state == aetf_pkg::S_DLY);

  // tap availability and ring position
  logic [CMPW-1:0] d_ext;
  logic tap_zero, tap_miss;
  logic [FW:0]     pos_sum, pos_red;
  logic [AW-1:0]   tap_addr, wr_addr;
  assign d_ext    = CMPW'(d);
  assign tap_zero = (d == '0);
  assign tap_miss = (d_ext > CMPW'(frames_seen)) || (d_ext >= CMPW'(HISTORY_FRAMES));
  assign pos_sum  = {1'b0, write_frame} + (FW+1)'(HISTORY_FRAMES) - (FW+1)'(d);
  assign pos_red  = (pos_sum >= (FW+1)'(HISTORY_FRAMES)) ?
                    pos_sum - (FW+1)'(HISTORY_FRAMES) : pos_sum;
  assign tap_addr = AW'(FW'(pos_red)) * AW'(MAX_CHANNELS) + AW'(cur_ch);
  assign wr_addr  = AW'(write_frame) * AW'(MAX_CHANNELS) + AW'(cur_ch);

  // modulated delay: dq = base<<15 + swing*sine, truncated toward zero
  logic signed [30:0] dq;
  logic dq_dry;
  logic [DW-1:0] d_mod;
  assign dq     = (31'(cfg_base) <<< 15) + 31'(mp);
  assign dq_dry = (dq <= -31'sd32768);
  assign d_mod  = dq[30] ? '0 : DW'(dq[30:15]);

  // tremolo factor 2^31 + gain*sine, always positive and below 2^32
  logic signed [PW-1:0] fac_sum;
  assign fac_sum = mp + ONE_Q31;

  // final truncating shift and saturation
  logic is_am;
  logic signed [PW-1:0] biased, shifted;
  assign is_am   = (cfg_mode == aetf_pkg::MODE_AM);
  assign biased  = acc + (acc[PW-1] ? (is_am ? BIAS_31 : BIAS_16) : '0);
  assign shifted = is_am ? (biased >>> 31) : (biased >>> 16);

  logic [TNW-1:0] taps_cfg;
  assign taps_cfg = (32'(cfg_tap_count) > MAX_TAPS) ? TNW'(MAX_TAPS) : TNW'(cfg_tap_count);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      aetf_pkg::S_IDLE:  if (din.valid) state_next = aetf_pkg::S_SETUP;
      aetf_pkg::S_SETUP: begin
        case (cfg_mode)
          aetf_pkg::MODE_ECHO:  state_next = aetf_pkg::S_TAP;
          aetf_pkg::MODE_MULTI: state_next = (taps_cfg == '0) ? aetf_pkg::S_FIN
                                                              : aetf_pkg::S_WGT;
          aetf_pkg::MODE_AM:    state_next = aetf_pkg::S_AMG;
          default:              state_next = aetf_pkg::S_DLY;
        endcase
      end
      aetf_pkg::S_WGT:  if (mul_done) state_next = aetf_pkg::S_TAP;
      aetf_pkg::S_TAP: begin
        if (tap_zero)      state_next = aetf_pkg::S_TMUL;
        else if (tap_miss) state_next = aetf_pkg::S_NEXT;
        else               state_next = aetf_pkg::S_RD;
      end
      aetf_pkg::S_RD:   state_next = aetf_pkg::S_RDW;
      aetf_pkg::S_RDW:  state_next = aetf_pkg::S_TMUL;
      aetf_pkg::S_TMUL: if (mul_done) state_next = aetf_pkg::S_NEXT;
      aetf_pkg::S_NEXT: begin
        if (cfg_mode == aetf_pkg::MODE_MULTI && tapn < ntaps) state_next = aetf_pkg::S_WGT;
        else                                                  state_next = aetf_pkg::S_FIN;
      end
      aetf_pkg::S_AMG:  if (mul_done) state_next = aetf_pkg::S_AMX;
      aetf_pkg::S_AMX:  if (mul_done) state_next = aetf_pkg::S_FIN;
      aetf_pkg::S_DLY:  if (mul_done) state_next = dq_dry ? aetf_pkg::S_FIN : aetf_pkg::S_TAP;
      aetf_pkg::S_FIN:  state_next = aetf_pkg::S_OUT;
      aetf_pkg::S_OUT:  if (!dout.valid || dout.ready) state_next = aetf_pkg::S_IDLE;
      default:          state_next = aetf_pkg::S_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    din.ready = (state == aetf_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= aetf_pkg::S_IDLE;
    else     state <= state_next;
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (mul_run && !mul_done) begin
      mp <= mp + (mb[0] ? ma : '0);
      ma <= ma <<< 1;
      mb <= mb >> 1;
    end
    case (state)
      aetf_pkg::S_IDLE: begin
        x      <= din.sample_in;
        cur_ch <= ch_now;
        sine   <= aetf_pkg::SINE_TAB[lfo_phase[23 -: aetf_pkg::SINE_IDX_W]];
      end
      aetf_pkg::S_SETUP: begin
        acc   <= PW'(x) <<< 16;
        tapn  <= TNW'(1);
        ntaps <= taps_cfg;
        w     <= 17'(cfg_gain);
        d     <= DW'(cfg_tap_delay);
        mp    <= '0;
        mb    <= aetf_pkg::MUL_B_W'(cfg_gain);
        case (cfg_mode)
          aetf_pkg::MODE_MULTI:     ma <= PW'(17'h10000);
          aetf_pkg::MODE_MOD_DELAY: begin
            ma <= PW'(sine);
            mb <= aetf_pkg::MUL_B_W'(cfg_swing);
          end
          default:                  ma <= PW'(sine);
        endcase
      end
      aetf_pkg::S_WGT: if (mul_done) w <= 17'(mp >>> 16);
      aetf_pkg::S_TAP: begin
        raddr <= tap_addr;
        if (tap_zero) begin
          ma <= PW'(x);
          mb <= aetf_pkg::MUL_B_W'(w);
          mp <= '0;
        end
      end
      aetf_pkg::S_RDW: begin
        ma <= PW'(rdata);
        mb <= aetf_pkg::MUL_B_W'(w);
        mp <= '0;
      end
      aetf_pkg::S_TMUL: if (mul_done) acc <= acc + mp;
      aetf_pkg::S_NEXT: begin
        // next echo tap: weight times gain again, delay one more spacing
        tapn <= tapn + TNW'(1);
        d    <= d + DW'(cfg_tap_delay);
        ma   <= PW'(w);
        mb   <= aetf_pkg::MUL_B_W'(cfg_gain);
        mp   <= '0;
      end
      aetf_pkg::S_AMG: if (mul_done) begin
        ma <= PW'(x);
        mb <= fac_sum[31:0];
        mp <= '0;
      end
      aetf_pkg::S_AMX: if (mul_done) acc <= mp;
      aetf_pkg::S_DLY: if (mul_done) d <= d_mod;
      aetf_pkg::S_FIN: begin
        if (shifted > SAT_HI) begin
          res_q  <= 16'sh7FFF;
          clip_q <= 1'b1;
        end else if (shifted < SAT_LO) begin
          res_q  <= 16'sh8000;
          clip_q <= 1'b1;
        end else begin
          res_q  <= shifted[15:0];
          clip_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------- history memory ----------------
  logic signed [15:0] ring [DEPTH];

  always_ff @(posedge clk) begin
    if (state == aetf_pkg::S_FIN) ring[wr_addr] <= x;
    rdata <= ring[raddr];
  end

  // ---------------- frame bookkeeping ----------------
  logic frame_end;
  assign frame_end = (32'(cur_ch) + 1 >= 32'(nch));

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen   <= '0;
      write_frame   <= '0;
      channel_index <= '0;
      lfo_phase     <= '0;
    end else if (state == aetf_pkg::S_FIN) begin
      if (frame_end) begin
        channel_index <= '0;
        write_frame   <= (write_frame == FW'(HISTORY_FRAMES - 1)) ? '0
                                                                  : write_frame + FW'(1);
        if (frames_seen < FSW'(HISTORY_FRAMES)) frames_seen <= frames_seen + FSW'(1);
        lfo_phase <= lfo_phase + 24'(cfg_lfo_step);
      end else begin
        channel_index <= cur_ch + CHW'(1);
      end
    end
  end

  // ---------------- output register ----------------
  logic               out_valid;
  logic signed [15:0] out_sample;
  logic               out_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == aetf_pkg::S_OUT && (!out_valid || dout.ready)) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == aetf_pkg::S_OUT && (!out_valid || dout.ready)) begin
      out_sample <= res_q;
      out_clip   <= clip_q;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;
  assign dout.clipped    = out_clip;

  // ---------------- assertions ----------------
  a_clip_rails: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.clipped |->
      (dout.sample_out == 16'sh7FFF || dout.sample_out == 16'sh8000))
    else $error("clipped item not at a rail");

  a_frames_bound: assert property (@(posedge clk) disable iff (rst)
    frames_seen <= FSW'(HISTORY_FRAMES))
    else $error("frames_seen beyond history");

  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> state == aetf_pkg::S_SETUP)
    else $error("accepted item did not start");

  a_tap_not_current: assert property (@(posedge clk) disable iff (rst)
    state == aetf_pkg::S_RD |-> raddr != wr_addr)
    else $error("tap read hits the slot being written");

endmodule
